// ===== src/ibs_pkg.sv =====
// shared constants, types and widths for the 4x4 binning sum block
// no dependencies

package ibs_pkg;

  // binning geometry
  localparam int BIN_FACTOR         = 4;
  localparam int BIN_LOG2           = 2;
  localparam int DEF_MAX_LINE_WIDTH = 4096;
  localparam int MAX_FRAME_ROWS     = 4096;

  // field and state widths
  localparam int PIX_W  = 16;
  localparam int HSUM_W = 18;
  localparam int SUM_W  = 20;
  localparam int CFG_W  = 13;
  localparam int ROW_W  = 12;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = CFG_W'(4096);
  localparam logic [CFG_W-1:0] FRAME_ROWS_RST = CFG_W'(4096);

  // configuration register indexes
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_FRAME_ROWS = REG_IDX_W'(1);

  // position within a bin
  localparam logic [BIN_LOG2-1:0] BIN_FIRST = BIN_LOG2'(0);
  localparam logic [BIN_LOG2-1:0] BIN_LAST  = BIN_LOG2'(BIN_FACTOR - 1);

  // per-pixel position flags from the counter unit
  typedef struct packed {
    logic grp_start;   // first pixel of a horizontal group
    logic grp_end;     // last pixel of a group inside a whole bin column
    logic band_start;  // pixel sits in the first row of a band
    logic emit;        // this pixel completes a whole bin
    logic eor;         // completed bin is the last of its output row
    logic eof;         // completed bin is the last of the frame
  } pos_t;

endpackage

// ===== src/ibs_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

module ibs_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ibs_pos.sv =====
// configuration registers, column and row counters, and bin position flags
// depends on ibs_pkg

module ibs_pos import ibs_pkg::*; #(
  parameter int MAX_LINE_WIDTH = DEF_MAX_LINE_WIDTH
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [REG_IDX_W-1:0]                      cfg_idx_i,
  input  logic [CFG_W-1:0]                          cfg_data_i,
  input  logic                                      adv_i,
  output pos_t                                      pos_o,
  output logic [$clog2(MAX_LINE_WIDTH/BIN_FACTOR)-1:0] addr_o
);

  localparam int COL_W  = $clog2(MAX_LINE_WIDTH);
  localparam int CMP_W  = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
  localparam int ADDR_W = $clog2(MAX_LINE_WIDTH / BIN_FACTOR);
  localparam int RCMP_W = ROW_W + 1;

  logic [CFG_W-1:0]  line_width_q;
  logic [CFG_W-1:0]  frame_rows_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;

  logic [CMP_W-1:0]  lw_ext, w_use, bins_x, bx_ext, col_next;
  logic [RCMP_W-1:0] fr_ext, h_use, bins_y, by_ext, row_next;
  logic              in_bin_col, in_bin_row, eor;

  // clamp the registers to the supported range
  always_comb begin
    lw_ext = CMP_W'(line_width_q);
    if (lw_ext < CMP_W'(BIN_FACTOR)) begin
      w_use = CMP_W'(BIN_FACTOR);
    end else if (lw_ext > CMP_W'(MAX_LINE_WIDTH)) begin
      w_use = CMP_W'(MAX_LINE_WIDTH);
    end else begin
      w_use = lw_ext;
    end
    fr_ext = RCMP_W'(frame_rows_q);
    if (fr_ext < RCMP_W'(BIN_FACTOR)) begin
      h_use = RCMP_W'(BIN_FACTOR);
    end else if (fr_ext > RCMP_W'(MAX_FRAME_ROWS)) begin
      h_use = RCMP_W'(MAX_FRAME_ROWS);
    end else begin
      h_use = fr_ext;
    end
  end

  assign bins_x     = w_use >> BIN_LOG2;
  assign bins_y     = h_use >> BIN_LOG2;
  assign bx_ext     = CMP_W'(col_q >> BIN_LOG2);
  assign by_ext     = RCMP_W'(row_q >> BIN_LOG2);
  assign in_bin_col = bx_ext < bins_x;
  assign in_bin_row = by_ext < bins_y;
  assign eor        = (bx_ext + CMP_W'(1)) == bins_x;

  always_comb begin
    pos_o.grp_start  = col_q[BIN_LOG2-1:0] == BIN_FIRST;
    pos_o.grp_end    = (col_q[BIN_LOG2-1:0] == BIN_LAST) && in_bin_col;
    pos_o.band_start = row_q[BIN_LOG2-1:0] == BIN_FIRST;
    pos_o.emit       = pos_o.grp_end && (row_q[BIN_LOG2-1:0] == BIN_LAST) && in_bin_row;
    pos_o.eor        = eor;
    pos_o.eof        = eor && ((by_ext + RCMP_W'(1)) == bins_y);
  end

  assign addr_o = ADDR_W'(col_q >> BIN_LOG2);

  // counters wrap when they reach or pass the width and height in use
  always_comb begin
    col_next = CMP_W'(col_q) + CMP_W'(1);
    row_next = RCMP_W'(row_q) + RCMP_W'(1);
    col_d    = col_q;
    row_d    = row_q;
    if (adv_i) begin
      if (col_next >= w_use) begin
        col_d = '0;
        row_d = (row_next >= h_use) ? '0 : row_next[ROW_W-1:0];
      end else begin
        col_d = col_next[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
      frame_rows_q <= FRAME_ROWS_RST;
      col_q        <= '0;
      row_q        <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LINE_WIDTH: line_width_q <= cfg_data_i;
          REG_FRAME_ROWS: frame_rows_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== src/image_binning_sum_4x4.sv =====
// top level of the 4x4 binning sum: horizontal adder, column-sum line store,
// result stage and output register; depends on ibs_pkg, ibs_pos and ibs_ram

// usage
//   input channel: one signed 16-bit pixel per word, raster order, moved on
//   in_valid_i high and in_stall_o low at a rising clock edge
//   output channel: one 20-bit bin sum per word with end-of-row and
//   end-of-frame marks, moved on out_valid_o high and out_stall_i low
//   configuration: cfg_we_i writes cfg_data_i to line_width (index 0) or
//   frame_rows (index 1); write only while the block is idle
//   throughput: one pixel per clock, sustained, as long as the output drains
//   order: the edge that accepts the word completing the bin loads the add
//   stage and starts the line store read; the output register takes the sum
//   as the add stage moves on, which a full, stalled output can hold back
//   the line store is a single ram of MAX_LINE_WIDTH/4 entries, one read and
//   one write port; a band's first row overwrites it, so no clearing pass
//   reset: counters, horizontal sum and valids cleared, registers back to
//   4096; the first pixel after reset is column 0 of row 0
//   receiver stall: the output register holds; the add stage holds the next
//   finished bin, and only then does in_stall_o rise

module image_binning_sum_4x4 import ibs_pkg::*; #(
  parameter int MAX_LINE_WIDTH = DEF_MAX_LINE_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [REG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  // pixel input
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [PIX_W-1:0] pixel_value_i,
  // bin sum output
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SUM_W-1:0] bin_sum_o,
  output logic                    end_of_bin_row_o,
  output logic                    end_of_frame_o
);

  localparam int STORE_DEPTH = MAX_LINE_WIDTH / BIN_FACTOR;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  pos_t              pos;
  logic [ADDR_W-1:0] addr;
  logic              accept;

  // horizontal running sum
  logic [HSUM_W-1:0] hsum_q, hsum_d;

  // add stage: one entry per completed horizontal group
  logic              s1_valid_q, s1_valid_d;
  logic [HSUM_W-1:0] s1_hsum_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic              s1_first_q, s1_emit_q, s1_eor_q, s1_eof_q;
  logic              s1_move;
  logic [SUM_W-1:0]  col_rd, col_acc;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [SUM_W-1:0]  out_sum_q;
  logic              out_eor_q, out_eof_q;
  logic              out_ready;

  ibs_pos #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .adv_i     (accept),
    .pos_o     (pos),
    .addr_o    (addr)
  );

  // handshake: the add stage advances unless its bin waits on a full, stalled output
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && (!s1_emit_q || out_ready);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign accept     = in_valid_i && !in_stall_o;

  // group sum: restart at the first pixel of every group of four
  always_comb begin
    hsum_d = hsum_q;
    if (accept) begin
      if (pos.grp_start) begin
        hsum_d = HSUM_W'(pixel_value_i);
      end else begin
        hsum_d = hsum_q + HSUM_W'(pixel_value_i);
      end
    end
  end

  // line store of per-bin column sums; read on the group's last pixel outside a
  // band's first row, written back as the add stage moves on
  ibs_ram #(
    .WIDTH(SUM_W),
    .DEPTH(STORE_DEPTH)
  ) u_col_ram (
    .clk_i  (clk_i),
    .we_i   (s1_move),
    .waddr_i(s1_addr_q),
    .wdata_i(col_acc),
    .re_i   (accept && pos.grp_end && !pos.band_start),
    .raddr_i(addr),
    .rdata_o(col_rd)
  );

  // first row of a band starts the column sum afresh
  assign col_acc = s1_first_q ? SUM_W'($signed(s1_hsum_q))
                              : col_rd + SUM_W'($signed(s1_hsum_q));

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept && pos.grp_end) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_move && s1_emit_q) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsum_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      hsum_q      <= hsum_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept && pos.grp_end) begin
      s1_hsum_q  <= hsum_d;
      s1_addr_q  <= addr;
      s1_first_q <= pos.band_start;
      s1_emit_q  <= pos.emit;
      s1_eor_q   <= pos.eor;
      s1_eof_q   <= pos.eof;
    end
    if (s1_move && s1_emit_q) begin
      out_sum_q <= col_acc;
      out_eor_q <= s1_eor_q;
      out_eof_q <= s1_eof_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign bin_sum_o        = $signed(out_sum_q);
  assign end_of_bin_row_o = out_eor_q;
  assign end_of_frame_o   = out_eof_q;

endmodule
